// ----- src/dcrh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrh_pkg
// Types and constants shared by the distance-coded reference homing block.
// ----------------------------------------------------------------------------
package dcrh_pkg;

   localparam int COUNT_WIDTH  = 32;
   localparam int NUM_SPACINGS = 7;
   localparam int CSR_IDX_W    = 1;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;
   typedef logic [1:0]             pass_cnt_type;

   localparam csr_idx_type CSR_UPPER_LIMIT = 1'b0;
   localparam csr_idx_type CSR_LOWER_LIMIT = 1'b1;

   localparam count_type UPPER_LIMIT_RST = 32'd400000;
   localparam count_type LOWER_LIMIT_RST = 32'd45000;

   localparam pass_cnt_type PASS_MAX = 2'd3;

   // known mark spacings, in counts
   localparam count_type SPACING [NUM_SPACINGS] = '{
      32'd28000, 32'd20000, 32'd30000, 32'd18000, 32'd32000, 32'd16000, 32'd34000
   };

   // absolute position of the previous mark, pole 2000, K 48000
   // forward: mark count increased; reverse: mark count decreased
   localparam count_type MARK_POS_FWD [NUM_SPACINGS] = '{
      32'd48000, 32'd76000, 32'd96000, 32'd126000, 32'd144000, 32'd176000, 32'd192000
   };
   localparam count_type MARK_POS_REV [NUM_SPACINGS] = '{
      32'd76000, 32'd96000, 32'd126000, 32'd144000, 32'd176000, 32'd192000, 32'd226000
   };

   typedef struct packed {
      logic      action;
      count_type count_value;
   } req_type;

   typedef struct packed {
      count_type abs_position;
      logic      at_upper_limit;
      logic      at_lower_limit;
      logic      is_calibrated;
   } rsp_type;

   typedef struct packed {
      count_type position_offset;
      logic      calibrated;
   } homing_status_type;

endpackage

// ----- src/dcrh_mark_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrh_mark_tracker
// Tracks reference-mark passes, decodes the mark distance and holds the
// position offset and the calibrated flag.
// ----------------------------------------------------------------------------
module dcrh_mark_tracker
   import dcrh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              mark_valid,
   input  count_type         mark_value,
   output homing_status_type status
);

   count_type    offset_ff, offset_in;
   count_type    prev_mark_ff, prev_mark_in;
   pass_cnt_type passes_ff, passes_in;
   logic         cal_ff, cal_in;

   logic      going_up;
   count_type span;
   logic      hit;
   count_type mark_pos;

   always_comb begin
      going_up = mark_value > prev_mark_ff;
      span     = going_up ? (mark_value - prev_mark_ff) : (prev_mark_ff - mark_value);
      hit      = 1'b0;
      mark_pos = '0;
      for (int i = 0; i < NUM_SPACINGS; i++) begin
         if (span == SPACING[i]) begin
            hit      = 1'b1;
            mark_pos = going_up ? MARK_POS_FWD[i] : MARK_POS_REV[i];
         end
      end
   end

   always_comb begin
      offset_in    = offset_ff;
      prev_mark_in = prev_mark_ff;
      passes_in    = passes_ff;
      cal_in       = cal_ff;
      if (mark_valid && (mark_value != prev_mark_ff)) begin
         if ((passes_ff == PASS_MAX) && hit) begin
            offset_in = mark_pos - prev_mark_ff;
            cal_in    = 1'b1;
         end
         prev_mark_in = mark_value;
         if (passes_ff != PASS_MAX) begin
            passes_in = passes_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         prev_mark_ff <= '0;
         passes_ff    <= '0;
         cal_ff       <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         prev_mark_ff <= prev_mark_in;
         passes_ff    <= passes_in;
         cal_ff       <= cal_in;
      end
   end

   assign status.position_offset = offset_ff;
   assign status.calibrated      = cal_ff;

   a_cal_needs_passes : assert property (@(posedge clock) disable iff (reset)
      cal_ff |-> (passes_ff == PASS_MAX))
      else $error("calibrated before three mark passes");

   a_cal_sticky : assert property (@(posedge clock) disable iff (reset)
      cal_ff |=> cal_ff)
      else $error("calibrated flag dropped");

   a_pass_saturate : assert property (@(posedge clock) disable iff (reset)
      (passes_ff == PASS_MAX) |=> (passes_ff == PASS_MAX))
      else $error("pass counter left saturation");

   a_offset_only_on_mark : assert property (@(posedge clock) disable iff (reset)
      !mark_valid |=> $stable(offset_ff) && $stable(prev_mark_ff))
      else $error("mark state changed without a mark");

endmodule

// ----- src/dcrh_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrh_out_buf
// Output register with a skid stage; ready toward the core is registered.
// ----------------------------------------------------------------------------
module dcrh_out_buf
   import dcrh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   logic push;
   logic pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;
   assign pop      = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a request while output is empty");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && push) |=> skid_valid_ff)
      else $error("stalled response lost an incoming request");

   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> !skid_valid_ff)
      else $error("skid did not drain on pop");

endmodule

// ----- src/distance_coded_reference_homing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_coded_reference_homing
// Path: a count sample passes the input register, then the output register,
//   before rsp_valid rises. Mark requests give no response.
// Throughput: one request per cycle, set by the single add/compare stage;
//   a sample request stalls while the output buffer is full.
// Reset: synchronous; offset, mark history and calibrated flag clear, limits
//   return to 400000 / 45000.
// ----------------------------------------------------------------------------
module distance_coded_reference_homing
   import dcrh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  count_type   csr_wdata
);

   count_type upper_ff, upper_in;
   count_type lower_ff, lower_in;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;

   homing_status_type status;
   logic              buf_ready;
   logic              s1_advance;
   logic              mark_valid;
   logic              sample_valid;
   rsp_type           sample_rsp;
   count_type         pos;

   assign csr_ready = 1'b1;

   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_UPPER_LIMIT: upper_in = csr_wdata;
            CSR_LOWER_LIMIT: lower_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign mark_valid   = s1_valid_ff && s1_data_ff.action;
   assign sample_valid = s1_valid_ff && !s1_data_ff.action;
   assign s1_advance   = mark_valid || (sample_valid && buf_ready);
   assign req_ready    = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff    <= UPPER_LIMIT_RST;
         lower_ff    <= LOWER_LIMIT_RST;
         s1_valid_ff <= 1'b0;
      end else begin
         upper_ff    <= upper_in;
         lower_ff    <= lower_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_data_ff <= s1_data_in;
   end

   assign pos = s1_data_ff.count_value + status.position_offset;

   always_comb begin
      sample_rsp.abs_position   = pos;
      sample_rsp.at_upper_limit = pos >= upper_ff;
      sample_rsp.at_lower_limit = pos <= lower_ff;
      sample_rsp.is_calibrated  = status.calibrated;
   end

   dcrh_mark_tracker u_mark_tracker (
      .clock      (clock),
      .reset      (reset),
      .mark_valid (mark_valid),
      .mark_value (s1_data_ff.count_value),
      .status     (status)
   );

   dcrh_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sample_valid),
      .in_ready  (buf_ready),
      .in_data   (sample_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_mark_never_stalls : assert property (@(posedge clock) disable iff (reset)
      mark_valid |-> req_ready)
      else $error("mark request stalled the input stage");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (sample_valid && !buf_ready) |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("stalled sample request lost");

   a_limits_quiet : assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(upper_ff) && $stable(lower_ff))
      else $error("limit changed without a register write");

endmodule
